>>> src/antn_pkg.sv
// ----------------------------------------------------------------------------
// antn_pkg
// Shared types and constants for the AR noise unit.
// ----------------------------------------------------------------------------
package antn_pkg;

  localparam int MAX_ORDER_DEF = 16;
  localparam int MAX_TONES_DEF = 8;
  localparam int SINE_DEPTH_DEF = 1024;

  localparam int DATA_W = 32;
  localparam int DIVD_W = 64;
  localparam int DIVS_W = 32;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = 64;
  localparam int SINE_W = 17;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam logic signed [ACC_W-1:0] ACC_LIMIT = 64'sd140737488355327;

  typedef enum logic [1:0] {
    CMD_LOAD_COEF = 2'd0,
    CMD_LOAD_TONE = 2'd1,
    CMD_SAMPLE    = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SAT    = 2'd1,
    ST_A0_ZERO = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_FILTER_ORDER = 2'd0,
    REG_TONE_COUNT   = 2'd1,
    REG_EXC_GAIN     = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

endpackage

>>> src/antn_if.sv
// ----------------------------------------------------------------------------
// antn_in_if / antn_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface antn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [4:0]  entry_index;
  logic signed [31:0] coefficient_word;
  logic [31:0] tone_freq;
  logic signed [31:0] tone_amp;
  logic [15:0] tone_phase_turns;
  logic signed [31:0] excitation;
  logic [31:0] sample_time;
  modport source (output valid, command, entry_index, coefficient_word, tone_freq,
                  tone_amp, tone_phase_turns, excitation, sample_time, input ready);
  modport sink (input valid, command, entry_index, coefficient_word, tone_freq,
                tone_amp, tone_phase_turns, excitation, sample_time, output ready);
endinterface

interface antn_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] noise_sample;
  logic signed [31:0] ar_part;
  logic [1:0]  status;
  modport source (output valid, noise_sample, ar_part, status, input ready);
  modport sink (input valid, noise_sample, ar_part, status, output ready);
endinterface

>>> src/antn_div.sv
// ----------------------------------------------------------------------------
// antn_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module antn_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [antn_pkg::DIVD_W-1:0] dividend,
  input  logic signed [antn_pkg::DIVS_W-1:0] divisor,
  output logic done,
  output logic signed [antn_pkg::DIVD_W-1:0] quotient
);
  import antn_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] q;
  logic [DIVS_W:0]   rem;
  logic [DIVS_W:0]   dsr;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIVS_W:0]   rem_sh;
  logic              take;

  assign rem_sh = {rem[DIVS_W-1:0], q[DIVD_W-1]};
  assign take = rem_sh >= dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DIVD_W);
        q <= dividend[DIVD_W-1] ? DIVD_W'(-dividend) : DIVD_W'(dividend);
        dsr <= divisor[DIVS_W-1] ? (DIVS_W+1)'(-{divisor[DIVS_W-1], divisor})
                                 : {1'b0, divisor};
        neg <= dividend[DIVD_W-1] ^ divisor[DIVS_W-1];
        rem <= '0;
      end else if (busy) begin
        rem <= take ? rem_sh - dsr : rem_sh;
        q <= {q[DIVD_W-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(q) : $signed(q);
endmodule

>>> src/ar_noise_with_tones_unit.sv
// ----------------------------------------------------------------------------
// ar_noise_with_tones_unit
// All-pole noise shaper plus summed sine tones, one shared multiplier.
// ----------------------------------------------------------------------------
// A sample beat: MAC over gain and a[1..order], divide by a[0], per tone
// phase, lookup, multiply, accumulate, then saturate; result registered.
// With a[0] zero the result is ready the cycle after acceptance.
// One beat at a time: ready only when idle with no result pending.
// Reset (rst, sync high) clears control, config and history; stores are
// undefined until loaded.
module ar_noise_with_tones_unit #(
  parameter int MAX_ORDER = antn_pkg::MAX_ORDER_DEF,
  parameter int MAX_TONES = antn_pkg::MAX_TONES_DEF,
  parameter int SINE_TABLE_DEPTH = antn_pkg::SINE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [31:0] cfg_data,
  antn_in_if.sink sample_in,
  antn_out_if.source result_out
);
  import antn_pkg::*;

  localparam int CW = $clog2(MAX_ORDER + 1);
  localparam int HW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int TW = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int KMAX = (MAX_ORDER > MAX_TONES) ? MAX_ORDER : MAX_TONES;
  localparam int KW = $clog2(KMAX + 1);
  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL  = 10'b0000000010,
    S_ACC  = 10'b0000000100,
    S_DSET = 10'b0000001000,
    S_DIV  = 10'b0000010000,
    S_TPH  = 10'b0000100000,
    S_TADR = 10'b0001000000,
    S_TMUL = 10'b0010000000,
    S_TACC = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  state_t state;

  logic [4:0] fb_order;
  logic [3:0] tone_count;
  logic signed [31:0] excitation_gain;

  logic signed [31:0] coefs [MAX_ORDER+1];
  logic [31:0] tfreq [MAX_TONES];
  logic signed [31:0] tamp [MAX_TONES];
  logic [15:0] tphase [MAX_TONES];
  logic signed [31:0] hist [MAX_ORDER];

  // Quarter-wave sine table, Taylor series through x^13 evaluated in Q2.30, entries unsigned Q1.16.
  logic [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint unsigned XQ =
        TWO_PI_Q30 * 64'(gi) / (64'd4 * 64'(SINE_TABLE_DEPTH));
    localparam longint unsigned X2Q = (XQ * XQ) >> 30;
    localparam longint unsigned T1 = ((XQ * X2Q) >> 30) / 64'd6;
    localparam longint unsigned T2 = ((T1 * X2Q) >> 30) / 64'd20;
    localparam longint unsigned T3 = ((T2 * X2Q) >> 30) / 64'd42;
    localparam longint unsigned T4 = ((T3 * X2Q) >> 30) / 64'd72;
    localparam longint unsigned T5 = ((T4 * X2Q) >> 30) / 64'd110;
    localparam longint unsigned T6 = ((T5 * X2Q) >> 30) / 64'd156;
    localparam longint SUMQ = longint'(XQ) - longint'(T1) + longint'(T2) - longint'(T3)
                              + longint'(T4) - longint'(T5) + longint'(T6);
    localparam longint RND = (((SUMQ < 64'sd0) ? 64'sd0 : SUMQ) + 64'sd8192) >>> 14;
    localparam longint CAPPED = (RND > 64'sd65536) ? 64'sd65536 : RND;
    assign sine_rom[gi] = SINE_W'(CAPPED);
  end

  logic signed [31:0] exc;
  logic [31:0] tsamp;
  logic [KW-1:0] k;
  logic [KW-1:0] order_eff;
  logic [KW-1:0] tones_eff;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] tsum;
  logic signed [ACC_W-1:0] pfloor;
  logic signed [31:0] ar;
  logic hit;
  logic [SINE_W-1:0] sine_q;
  logic sine_neg;

  logic div_start;
  logic div_done;
  logic signed [DIVD_W-1:0] div_q;
  logic signed [ACC_W-1:0] acc_cl;
  logic [31:0] turn;
  logic [63:0] pp;
  logic [AW-1:0] p;
  logic [AW-1:0] rom_addr;
  logic signed [ACC_W-1:0] total_w;
  logic [31:0] idx32;

  logic out_valid;
  logic signed [31:0] out_noise;
  logic signed [31:0] out_ar;
  logic [1:0] out_status;

  assign idx32 = 32'(sample_in.entry_index);
  assign order_eff = (32'(fb_order) > MAX_ORDER) ? KW'(MAX_ORDER) : KW'(fb_order);
  assign tones_eff = (32'(tone_count) > MAX_TONES) ? KW'(MAX_TONES) : KW'(tone_count);
  assign sample_in.ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL: begin
        if (k == '0) begin
          mul_a = MUL_W'(excitation_gain);
          mul_b = MUL_W'(exc);
        end else begin
          mul_a = MUL_W'(coefs[k[CW-1:0]]);
          mul_b = MUL_W'(hist[HW'(k - 1'b1)]);
        end
      end
      S_TPH: begin
        mul_a = {1'b0, tfreq[k[TW-1:0]]};
        mul_b = {1'b0, tsamp};
      end
      S_TMUL: begin
        mul_a = MUL_W'(tamp[k[TW-1:0]]);
        mul_b = sine_neg ? -MUL_W'({1'b0, sine_q}) : MUL_W'({1'b0, sine_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign pfloor = ACC_W'(prod >>> 16);
  assign acc_cl = (acc > ACC_LIMIT) ? ACC_LIMIT : ((acc < -ACC_LIMIT) ? -ACC_LIMIT : acc);
  assign turn = prod[31:0] + {tphase[k[TW-1:0]], 16'd0};
  assign pp = 64'(turn[29:0]) * 64'(SINE_TABLE_DEPTH);
  assign p = pp[30+AW-1:30];
  assign rom_addr = turn[30] ? AW'(SINE_TABLE_DEPTH) - p : p;
  assign total_w = ACC_W'(ar) + tsum;

  antn_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(acc_cl <<< 16),
    .divisor(coefs[0]),
    .done(div_done),
    .quotient(div_q)
  );

  assign div_start = (state == S_DSET);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      if (sample_in.command == CMD_LOAD_COEF && idx32 <= MAX_ORDER) begin
        coefs[idx32[CW-1:0]] <= sample_in.coefficient_word;
      end
      if (sample_in.command == CMD_LOAD_TONE && idx32 < MAX_TONES) begin
        tfreq[idx32[TW-1:0]] <= sample_in.tone_freq;
        tamp[idx32[TW-1:0]] <= sample_in.tone_amp;
        tphase[idx32[TW-1:0]] <= sample_in.tone_phase_turns;
      end
      exc <= sample_in.excitation;
      tsamp <= sample_in.sample_time;
    end
    if (state == S_TADR) begin
      sine_q <= sine_rom[rom_addr];
      sine_neg <= turn[31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fb_order <= '0;
      tone_count <= '0;
      excitation_gain <= '0;
      out_valid <= 1'b0;
      k <= '0;
      for (int j = 0; j < MAX_ORDER; j++) hist[j] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FILTER_ORDER: fb_order <= cfg_data[4:0];
          REG_TONE_COUNT:   tone_count <= cfg_data[3:0];
          REG_EXC_GAIN:     excitation_gain <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && result_out.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (sample_in.valid && sample_in.ready &&
              sample_in.command == CMD_SAMPLE) begin
            if (coefs[0] == '0) begin
              out_valid <= 1'b1;
              out_noise <= '0;
              out_ar <= '0;
              out_status <= ST_A0_ZERO;
            end else begin
              k <= '0;
              hit <= 1'b0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          acc <= (k == '0) ? pfloor : acc - pfloor;
          if (k == order_eff) begin
            state <= S_DSET;
          end else begin
            k <= k + 1'b1;
            state <= S_MUL;
          end
        end
        S_DSET: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            if (div_q > 64'sd2147483647) begin
              ar <= 32'sh7fffffff;
              hit <= 1'b1;
            end else if (div_q < -64'sd2147483648) begin
              ar <= 32'sh80000000;
              hit <= 1'b1;
            end else begin
              ar <= div_q[31:0];
            end
            for (int j = 0; j < MAX_ORDER; j++) begin
              if (KW'(j) < order_eff) begin
                if (j == 0) begin
                  if (div_q > 64'sd2147483647) hist[j] <= 32'sh7fffffff;
                  else if (div_q < -64'sd2147483648) hist[j] <= 32'sh80000000;
                  else hist[j] <= div_q[31:0];
                end else begin
                  hist[j] <= hist[j-1];
                end
              end
            end
            tsum <= '0;
            k <= '0;
            state <= (tones_eff == '0) ? S_FIN : S_TPH;
          end
        end
        S_TPH:  state <= S_TADR;
        S_TADR: state <= S_TMUL;
        S_TMUL: state <= S_TACC;
        S_TACC: begin
          tsum <= tsum + pfloor;
          if (k == tones_eff - 1'b1) begin
            state <= S_FIN;
          end else begin
            k <= k + 1'b1;
            state <= S_TPH;
          end
        end
        S_FIN: begin
          out_valid <= 1'b1;
          out_ar <= ar;
          if (total_w > 64'sd2147483647) begin
            out_noise <= 32'sh7fffffff;
            out_status <= ST_SAT;
          end else if (total_w < -64'sd2147483648) begin
            out_noise <= 32'sh80000000;
            out_status <= ST_SAT;
          end else begin
            out_noise <= total_w[31:0];
            out_status <= hit ? ST_SAT : ST_OK;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.noise_sample = out_noise;
  assign result_out.ar_part = out_ar;
  assign result_out.status = out_status;

`ifndef SYNTH
  a_zero_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_A0_ZERO |-> out_noise == '0 && out_ar == '0)
    else $error("a0 zero result not cleared");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status != ST_UNUSED)
    else $error("bad status code");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample_in.ready |-> !out_valid && state == S_IDLE)
    else $error("ready while busy");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    state == S_DSET |=> state == S_DIV)
    else $error("divider not entered");
`endif
endmodule
